// ----- sv/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and constants for the multi-alphabet Base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Sextet values where the lower-case and digit ranges start, and the
  // two symbol values
  localparam logic [5:0] VAL_LOWER_BASE = 6'd26;
  localparam logic [5:0] VAL_DIGIT_BASE = 6'd52;
  localparam logic [5:0] VAL_PLUS       = 6'd62;
  localparam logic [5:0] VAL_SLASH      = 6'd63;

  // Masks for the leftover bits
  localparam logic [5:0] MASK2 = 6'h03;
  localparam logic [5:0] MASK4 = 6'h0F;

  // Number of leftover bits, counted in pairs
  localparam logic [1:0] HOLD_NONE = 2'd0;
  localparam logic [1:0] HOLD_TWO  = 2'd1;
  localparam logic [1:0] HOLD_FOUR = 2'd2;
  localparam logic [1:0] HOLD_SIX  = 2'd3;

  typedef struct packed {
    logic [7:0] text_char;
    logic       message_end;
  } char_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_done;
    logic       invalid_seen;
  } result_item_t;

  // Output of the character lookup
  typedef struct packed {
    logic       hit;
    logic [5:0] value;
  } sextet_t;

endpackage

// ----- sv/b64d_char_map.sv -----
// ----------------------------------------------------------------------------
// b64d_char_map
// Maps one raw character to its 6-bit value; flags characters outside
// every supported alphabet.
// ----------------------------------------------------------------------------
module b64d_char_map (
  input  logic [7:0]        text_char,
  output b64d_pkg::sextet_t sextet
);

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_USCORE  = 8'h5F;
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;

  logic [7:0] upper_off;
  logic [7:0] lower_off;
  logic [7:0] digit_off;

  assign upper_off = text_char - CHAR_UPPER_A;
  assign lower_off = text_char - CHAR_LOWER_A;
  assign digit_off = text_char - CHAR_ZERO;

  always_comb begin
    sextet.hit   = 1'b1;
    sextet.value = 6'd0;
    if (text_char >= CHAR_UPPER_A && text_char <= CHAR_UPPER_Z) begin
      sextet.value = upper_off[5:0];
    end else if (text_char >= CHAR_LOWER_A && text_char <= CHAR_LOWER_Z) begin
      sextet.value = lower_off[5:0] + b64d_pkg::VAL_LOWER_BASE;
    end else if (text_char >= CHAR_ZERO && text_char <= CHAR_NINE) begin
      sextet.value = digit_off[5:0] + b64d_pkg::VAL_DIGIT_BASE;
    end else if (text_char == CHAR_PLUS || text_char == CHAR_MINUS) begin
      sextet.value = b64d_pkg::VAL_PLUS;
    end else if (text_char == CHAR_SLASH || text_char == CHAR_USCORE ||
                 text_char == CHAR_COMMA) begin
      sextet.value = b64d_pkg::VAL_SLASH;
    end else begin
      sextet.hit = 1'b0;
    end
  end

endmodule

// ----- sv/base64_multi_alphabet_decoder.sv -----
// ----------------------------------------------------------------------------
// base64_multi_alphabet_decoder
// Unpadded Base64 decoder taking standard and URL-safe alphabets at once.
// ----------------------------------------------------------------------------
// Path: an accepted character is registered in the input stage, and its
//   result in the result register (the input register feeds it directly).
// Throughput: one character per cycle; the leftover-bit merge is a short
//   shift and select that finishes within the cycle. An item with a result
//   waits in the input register only while a result is held unaccepted.
// Reset (rst, synchronous): both stages empty, no bits held, invalid flag
//   clear.
module base64_multi_alphabet_decoder (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   char_valid,
  output logic                   char_ready,
  input  b64d_pkg::char_item_t   char_item,
  output logic                   res_valid,
  input  logic                   res_ready,
  output b64d_pkg::result_item_t res_item
);

  // Input stage
  logic                 in_full;
  b64d_pkg::char_item_t in_item;

  // Decode state
  logic [5:0] held_bits;
  logic [5:0] held_bits_next;
  logic [1:0] held_count;
  logic [1:0] held_count_next;
  logic       invalid_flag;
  logic       invalid_flag_next;

  b64d_pkg::sextet_t      sextet;
  b64d_pkg::result_item_t result_next;
  logic                   have_byte;
  logic [7:0]             byte_next;
  logic                   emits;
  logic                   out_free;
  logic                   advance;

  b64d_char_map u_char_map (
    .text_char (in_item.text_char),
    .sextet    (sextet)
  );

  // Merge the new sextet with the leftover bits, MSB first
  always_comb begin
    have_byte       = 1'b0;
    byte_next       = 8'd0;
    held_bits_next  = held_bits;
    held_count_next = held_count;
    if (sextet.hit) begin
      case (held_count)
        b64d_pkg::HOLD_NONE: begin
          held_bits_next  = sextet.value;
          held_count_next = b64d_pkg::HOLD_SIX;
        end
        b64d_pkg::HOLD_TWO: begin
          have_byte       = 1'b1;
          byte_next       = {held_bits[1:0], sextet.value};
          held_bits_next  = 6'd0;
          held_count_next = b64d_pkg::HOLD_NONE;
        end
        b64d_pkg::HOLD_FOUR: begin
          have_byte       = 1'b1;
          byte_next       = {held_bits[3:0], sextet.value[5:2]};
          held_bits_next  = sextet.value & b64d_pkg::MASK2;
          held_count_next = b64d_pkg::HOLD_TWO;
        end
        default: begin
          have_byte       = 1'b1;
          byte_next       = {held_bits, sextet.value[5:4]};
          held_bits_next  = sextet.value & b64d_pkg::MASK4;
          held_count_next = b64d_pkg::HOLD_FOUR;
        end
      endcase
    end
    invalid_flag_next = invalid_flag | ~sextet.hit;

    result_next.data_byte    = byte_next;
    result_next.byte_valid   = have_byte;
    result_next.message_done = in_item.message_end;
    result_next.invalid_seen = in_item.message_end & invalid_flag_next;

    // message end drops leftover bits and clears the flag
    if (in_item.message_end) begin
      held_bits_next    = 6'd0;
      held_count_next   = b64d_pkg::HOLD_NONE;
      invalid_flag_next = 1'b0;
    end
  end

  // An item that yields nothing leaves at once; one with a result needs
  // room in the result register
  assign emits      = have_byte | in_item.message_end;
  assign out_free   = ~res_valid | res_ready;
  assign advance    = in_full & (~emits | out_free);
  assign char_ready = ~in_full | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (char_ready) begin
      in_full <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      in_item <= char_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_bits    <= 6'd0;
      held_count   <= b64d_pkg::HOLD_NONE;
      invalid_flag <= 1'b0;
    end else if (advance) begin
      held_bits    <= held_bits_next;
      held_count   <= held_count_next;
      invalid_flag <= invalid_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= advance & emits;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emits) begin
      res_item <= result_next;
    end
  end

  // A result without a byte can only be the closing one
  a_empty_closes: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.byte_valid |-> res_item.message_done)
    else $error("result with neither byte nor message end");

  // Invalid report only rides on the closing result
  a_invalid_at_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.invalid_seen |-> res_item.message_done)
    else $error("invalid flag reported before message end");

  // No bits held means the holding register is clear
  a_held_clear: assert property (@(posedge clk) disable iff (rst)
    held_count == b64d_pkg::HOLD_NONE |-> held_bits == 6'd0)
    else $error("stale leftover bits");

  // A closing item leaves the decode state at reset values
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    advance && in_item.message_end |=>
      held_count == b64d_pkg::HOLD_NONE && !invalid_flag)
    else $error("state not cleared after message end");

endmodule

// ----- tb/b64d_decode_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// b64d_decode_checker
// Watches both channels of the Base64 decoder, keeps its own copy of the
// sextet packing state, and checks every result item against the oldest
// predicted one.
// ----------------------------------------------------------------------------
module b64d_decode_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   char_valid,
  input  logic                   char_ready,
  input  b64d_pkg::char_item_t   char_item,
  input  logic                   res_valid,
  input  logic                   res_ready,
  input  b64d_pkg::result_item_t res_item,
  output int                     fail_count,
  output int                     outstanding
);

  localparam int REPORT_LIMIT = 10;

  logic [5:0]             held_bits;
  logic [1:0]             held_count;
  logic                   invalid_flag;
  b64d_pkg::result_item_t predicted_bytes[$];

  // Character to sextet, across all accepted alphabets
  function automatic b64d_pkg::sextet_t lookup_sextet(input logic [7:0] c);
    b64d_pkg::sextet_t s;
    logic [7:0]        offs;
    s.hit   = 1'b1;
    s.value = '0;
    offs    = '0;
    if (c >= "A" && c <= "Z") begin
      offs    = c - "A";
      s.value = offs[5:0];
    end else if (c >= "a" && c <= "z") begin
      offs    = c - "a";
      s.value = offs[5:0] + b64d_pkg::VAL_LOWER_BASE;
    end else if (c >= "0" && c <= "9") begin
      offs    = c - "0";
      s.value = offs[5:0] + b64d_pkg::VAL_DIGIT_BASE;
    end else if (c == "+" || c == "-") begin
      s.value = b64d_pkg::VAL_PLUS;
    end else if (c == "/" || c == "_" || c == ",") begin
      s.value = b64d_pkg::VAL_SLASH;
    end else begin
      s.hit = 1'b0;
    end
    return s;
  endfunction

  task automatic absorb_char(input b64d_pkg::char_item_t it);
    b64d_pkg::sextet_t      s;
    b64d_pkg::result_item_t r;
    logic                   got_byte;
    s        = lookup_sextet(it.text_char);
    r        = '0;
    got_byte = 1'b0;
    if (s.hit) begin
      case (held_count)
        b64d_pkg::HOLD_NONE: begin
          held_bits  = s.value;
          held_count = b64d_pkg::HOLD_SIX;
        end
        b64d_pkg::HOLD_TWO: begin
          r.data_byte = {held_bits[1:0], s.value};
          got_byte    = 1'b1;
          held_bits   = '0;
          held_count  = b64d_pkg::HOLD_NONE;
        end
        b64d_pkg::HOLD_FOUR: begin
          r.data_byte = {held_bits[3:0], s.value[5:2]};
          got_byte    = 1'b1;
          held_bits   = s.value & b64d_pkg::MASK2;
          held_count  = b64d_pkg::HOLD_TWO;
        end
        default: begin
          r.data_byte = {held_bits, s.value[5:4]};
          got_byte    = 1'b1;
          held_bits   = s.value & b64d_pkg::MASK4;
          held_count  = b64d_pkg::HOLD_FOUR;
        end
      endcase
    end else begin
      invalid_flag = 1'b1;
    end
    if (got_byte || it.message_end) begin
      r.byte_valid   = got_byte;
      r.message_done = it.message_end;
      r.invalid_seen = it.message_end & invalid_flag;
      predicted_bytes.push_back(r);
    end
    // end of message: leftover bits are simply dropped
    if (it.message_end) begin
      held_bits    = '0;
      held_count   = b64d_pkg::HOLD_NONE;
      invalid_flag = 1'b0;
    end
  endtask

  task automatic check_result(input b64d_pkg::result_item_t got);
    b64d_pkg::result_item_t want;
    if (predicted_bytes.size() == 0) begin
      if (fail_count < REPORT_LIMIT)
        $display("%0t: result item with none predicted: byte %02h bv %b done %b inv %b",
                 $realtime, got.data_byte, got.byte_valid, got.message_done,
                 got.invalid_seen);
      fail_count++;
    end else begin
      want = predicted_bytes.pop_front();
      if (got.data_byte !== want.data_byte || got.byte_valid !== want.byte_valid ||
          got.message_done !== want.message_done ||
          got.invalid_seen !== want.invalid_seen) begin
        if (fail_count < REPORT_LIMIT)
          $display("%0t: mismatch exp %02h/%b/%b/%b got %02h/%b/%b/%b",
                   $realtime, want.data_byte, want.byte_valid, want.message_done,
                   want.invalid_seen, got.data_byte, got.byte_valid, got.message_done,
                   got.invalid_seen);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_bits    = '0;
      held_count   = b64d_pkg::HOLD_NONE;
      invalid_flag = 1'b0;
      fail_count   = 0;
      predicted_bytes.delete();
    end else begin
      if (char_valid && char_ready) absorb_char(char_item);
      if (res_valid && res_ready) check_result(res_item);
    end
    outstanding <= predicted_bytes.size();
  end

endmodule

// ----- tb/tb_base64_multi_alphabet_decoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_base64_multi_alphabet_decoder
// Drives encoded text into the decoder, one character per item, with random
// gaps and back-pressure; a side checker predicts and compares the decoded
// bytes and end-of-message markers.
// ----------------------------------------------------------------------------
module tb_base64_multi_alphabet_decoder;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 3;
  localparam int RANDOM_ITEMS   = 1830;
  // tail of the run with neither side idling
  localparam int QUIET_TAIL     = 150;
  // two-stage pipe, plus margin
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  logic                   clk;
  logic                   rst;
  logic                   char_valid;
  logic                   char_ready;
  b64d_pkg::char_item_t   char_item;
  logic                   res_valid;
  logic                   res_ready;
  b64d_pkg::result_item_t res_item;

  int   fail_count;
  int   outstanding;
  int   sent_count;
  int   stall_left;
  int   quiet_cycles;
  // sender idling is decided inside the stimulus process; the receiver's
  // flag is a separate copy updated at the clock edge
  logic send_idle;
  logic recv_idle;

  base64_multi_alphabet_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_item   (res_item)
  );

  b64d_decode_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .char_item   (char_item),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_item    (res_item),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Receiver: random stall bursts while idling is on
  always @(posedge clk) begin
    if (rst || !recv_idle) begin
      res_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      res_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      res_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      res_ready <= 1'b1;
    end
  end

  // Watchdog: too long with nothing accepted on either channel
  always @(posedge clk) begin
    if (rst || (char_valid && char_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Random character from the union of the alphabets
  function automatic logic [7:0] alphabet_char();
    int r;
    r = $urandom_range(0, 66);
    if (r < 26) return 8'("A" + r);
    if (r < 52) return 8'("a" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    case (r)
      62:      return "+";
      63:      return "-";
      64:      return "/";
      65:      return "_";
      default: return ",";
    endcase
  endfunction

  // One item; returns on the edge that accepts it. Valid stays high into
  // the next call unless a gap is drawn.
  task automatic send_item(input logic [7:0] ch, input logic last);
    int gap;
    if (send_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_item  <= '{text_char: ch, message_end: last};
    char_valid <= 1'b1;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
  endtask

  task automatic send_text(input string txt, input logic close);
    for (int i = 0; i < txt.len(); i++)
      send_item(txt[i], close && (i == txt.len() - 1));
  endtask

  // Random message; bad_pct is the share of raw bytes in place of
  // alphabet characters
  task automatic send_message(input int len, input int bad_pct);
    logic [7:0] ch;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < bad_pct) ch = 8'($urandom_range(0, 255));
      else ch = alphabet_char();
      send_item(ch, i == len - 1);
    end
    sent_count += len;
  endtask

  // Hold the sender back until every predicted item has come out.
  // The first wait lets the checker's count catch up with the last item.
  task automatic drain_results();
    char_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int kind;
    int len;
    rst        = 1'b1;
    char_valid = 1'b0;
    char_item  = '0;
    send_idle  = 1'b1;
    recv_idle  = 1'b1;
    sent_count = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: a plain triple, the two symbol alphabets, range edges,
    // leftover bits at the end, skipped bytes incl. padding and high bytes,
    // a skipped final character, and one-character messages
    send_text("TWFu", 1'b1);
    send_text("-_,+", 1'b1);
    send_text("AZaz", 1'b0);
    send_text("09", 1'b1);
    send_item("Q", 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_item("=", 1'b1);
    send_item("A", 1'b1);
    send_item(8'h7F, 1'b1);
    drain_results();

    // Random: mostly clean messages, some broken, some raw noise
    while (sent_count < RANDOM_ITEMS) begin
      send_idle = (sent_count < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      recv_idle <= send_idle;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
        send_message(len, 0);
      end else if (kind < 9) begin
        send_message($urandom_range(1, 24), 15);
      end else begin
        send_message($urandom_range(1, 8), 100);
      end
      if ($urandom_range(0, 15) == 0) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
